// File: hw/rtl/pbfe_pkg.sv
// pbfe_pkg: types, operation codes and constants for the protobuf field encoder
// used by every module under hw/rtl; depends on nothing
package pbfe_pkg;

   // operation codes of the request beat
   localparam logic [1:0] OP_INTEGER = 2'd0;
   localparam logic [1:0] OP_HEADER  = 2'd1;
   localparam logic [1:0] OP_RAW     = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // wire types placed in the low bits of a tag
   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam int unsigned TAG_SHIFT  = 3;

   localparam logic [7:0] CONT_BIT   = 8'h80;
   localparam logic [6:0] GROUP_MASK = 7'h7F;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [28:0]        field_number;
      logic signed [31:0] int_value;
      logic [31:0]        length;
      logic [7:0]         data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // classified work for the back end; raw bytes ride in the low bits of value
   typedef struct packed {
      logic        raw;
      logic [31:0] tag;
      logic [63:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_TAG = 3'b001,
      PH_VAL = 3'b010,
      PH_RAW = 3'b100
   } phase_type;

endpackage

// File: hw/rtl/pbfe_front.sv
// pbfe_front: accepts request beats, builds the tag word and the value word
// depends on pbfe_pkg
module pbfe_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  pbfe_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output pbfe_pkg::cmd_type q_cmd
);

   logic [2:0]  wire_kind;
   logic [31:0] tag_word;

   assign req_ready = !q_full;

   // the unused operation code is swallowed without queue traffic
   assign q_push = req_valid && req_ready && (req_data.operation != pbfe_pkg::OP_UNUSED);

   always_comb begin
      wire_kind = (req_data.operation == pbfe_pkg::OP_HEADER) ? pbfe_pkg::WIRE_LEN
                                                              : pbfe_pkg::WIRE_VARINT;
      tag_word  = {req_data.field_number, wire_kind};
      q_cmd.raw = 1'b0;
      q_cmd.tag = tag_word;
      case (req_data.operation)
         pbfe_pkg::OP_INTEGER: begin
            // int32 sign-extended to 64 bits
            q_cmd.value = {{32{req_data.int_value[31]}}, req_data.int_value};
         end
         pbfe_pkg::OP_HEADER: begin
            q_cmd.value = {32'd0, req_data.length};
         end
         pbfe_pkg::OP_RAW: begin
            q_cmd.raw   = 1'b1;
            q_cmd.value = {56'd0, req_data.data_byte};
         end
         default: begin
            q_cmd.value = 64'd0;
         end
      endcase
   end

endmodule

// File: hw/rtl/pbfe_queue.sv
// pbfe_queue: short first-in first-out queue of classified commands
// depends on pbfe_pkg
module pbfe_queue #(
   parameter int unsigned DEPTH = pbfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbfe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output pbfe_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   pbfe_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/pbfe_back.sv
// pbfe_back: serializes one command into varint bytes (a raw command as its one byte), one per
// cycle while the response is not stalled, into the response register; depends on pbfe_pkg
module pbfe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  pbfe_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbfe_pkg::rsp_type rsp_data
);

   logic                busy_ff, busy_in;
   pbfe_pkg::phase_type phase_ff, phase_in;
   logic [63:0]         word_ff, word_in;
   logic [63:0]         value_ff, value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pbfe_pkg::rsp_type   rsp_ff, rsp_in;

   logic       advance;
   logic       seg_more;
   logic       finish;
   logic [7:0] vbyte;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign seg_more = |word_ff[63:7];
   assign vbyte    = seg_more ? (pbfe_pkg::CONT_BIT | {1'b0, word_ff[6:0] & pbfe_pkg::GROUP_MASK})
                              : {1'b0, word_ff[6:0] & pbfe_pkg::GROUP_MASK};
   assign finish   = busy_ff && ((phase_ff == pbfe_pkg::PH_RAW)
                                 || ((phase_ff == pbfe_pkg::PH_VAL) && !seg_more));
   // next command loads while the last byte of the current one goes out
   assign q_pop    = advance && (!busy_ff || finish) && !q_empty;

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      value_in     = value_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            case (phase_ff)
               pbfe_pkg::PH_TAG: begin
                  rsp_in.out_byte = vbyte;
                  rsp_in.last     = 1'b0;
                  if (seg_more) begin
                     word_in = word_ff >> 7;
                  end else begin
                     word_in  = value_ff;
                     phase_in = pbfe_pkg::PH_VAL;
                  end
               end
               pbfe_pkg::PH_VAL: begin
                  rsp_in.out_byte = vbyte;
                  rsp_in.last     = !seg_more;
                  word_in         = word_ff >> 7;
               end
               pbfe_pkg::PH_RAW: begin
                  rsp_in.out_byte = word_ff[7:0];
                  rsp_in.last     = 1'b1;
               end
               default: begin
                  rsp_in = rsp_ff;
               end
            endcase
            if (finish) begin
               busy_in = 1'b0;
            end
         end
      end
      if (q_pop) begin
         busy_in  = 1'b1;
         value_in = q_cmd.value;
         if (q_cmd.raw) begin
            phase_in = pbfe_pkg::PH_RAW;
            word_in  = q_cmd.value;
         end else begin
            phase_in = pbfe_pkg::PH_TAG;
            word_in  = {32'd0, q_cmd.tag};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= pbfe_pkg::PH_TAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/protobuf_field_encoder.sv
// protobuf_field_encoder: top level, front classifier, command queue, byte serializer
// depends on pbfe_pkg, pbfe_front, pbfe_queue, pbfe_back
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_ready   req_data  (pbfe_pkg::req_type)
//  rsp      out  rsp_valid/rsp_ready   rsp_data  (pbfe_pkg::rsp_type)
//
// a raw item emits its one byte; an integer or header item emits tag bytes (1..5)
// plus value bytes (1..10), all sent by the serializer
// reset is synchronous and clears the queue, serializer and response valid flag
// the front keeps taking beats until the queue fills, while a held response waits
// the unused operation code is accepted and yields no beat
module protobuf_field_encoder #(
   parameter int unsigned QUEUE_DEPTH = pbfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbfe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbfe_pkg::rsp_type rsp_data
);

   logic              q_push, q_pop, q_full, q_empty;
   pbfe_pkg::cmd_type q_in_cmd, q_head_cmd;

   pbfe_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_in_cmd)
   );

   pbfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   pbfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("serializer popped an empty queue");

   a_raw_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.operation == pbfe_pkg::OP_RAW))
      |-> (q_push && q_in_cmd.raw))
      else $error("accepted raw beat not queued as raw");

   a_unused_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_data.operation == pbfe_pkg::OP_UNUSED) |-> !q_push)
      else $error("unused operation reached the queue");

endmodule

// File: verif/protobuf_field_encoder_tb.sv
// protobuf_field_encoder_tb: self-checking bench for the protobuf field encoder
// predicts the wire bytes of each accepted request and checks every response beat
// depends on pbfe_pkg and protobuf_field_encoder
module protobuf_field_encoder_tb;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pbfe_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pbfe_pkg::rsp_type rsp_data;

   pbfe_pkg::rsp_type wire_bytes_due[$];
   int                errors;
   int                beats_checked;
   int                items_by_op[4];
   bit                tx_gaps_on;
   bit                rsp_stall_on;

   protobuf_field_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   // mostly back to back, sometimes a short gap, rarely a long gap
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- prediction

   task automatic push_varint(input logic [63:0] v);
      pbfe_pkg::rsp_type b;
      b.last = 1'b0;
      while (v >= 64'(pbfe_pkg::CONT_BIT)) begin
         b.out_byte = pbfe_pkg::CONT_BIT | {1'b0, v[6:0] & pbfe_pkg::GROUP_MASK};
         wire_bytes_due = {wire_bytes_due, b};
         v = v >> 7;
      end
      b.out_byte = {1'b0, v[6:0] & pbfe_pkg::GROUP_MASK};
      wire_bytes_due = {wire_bytes_due, b};
   endtask

   task automatic encode_item(input pbfe_pkg::req_type it);
      pbfe_pkg::rsp_type b;
      int                n0;
      n0 = wire_bytes_due.size();
      case (it.operation)
         pbfe_pkg::OP_INTEGER: begin
            push_varint({32'd0, it.field_number, pbfe_pkg::WIRE_VARINT});
            // int32 goes out sign-extended to 64 bits
            push_varint({{32{it.int_value[31]}}, it.int_value});
         end
         pbfe_pkg::OP_HEADER: begin
            push_varint({32'd0, it.field_number, pbfe_pkg::WIRE_LEN});
            push_varint({32'd0, it.length});
         end
         pbfe_pkg::OP_RAW: begin
            b.out_byte = it.data_byte;
            b.last     = 1'b0;
            wire_bytes_due = {wire_bytes_due, b};
         end
         default: ;
      endcase
      if (wire_bytes_due.size() > n0) begin
         wire_bytes_due[wire_bytes_due.size() - 1].last = 1'b1;
      end
   endtask

   // prediction and checking share one process so the order within an edge is fixed
   always @(posedge clock) begin
      pbfe_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            items_by_op[req_data.operation]++;
            encode_item(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (wire_bytes_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected beat: byte %02h last %b", rsp_data.out_byte,
                           rsp_data.last);
            end else begin
               want = wire_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch at beat %0d: expected byte %02h last %b,",
                               " got byte %02h last %b"},
                              beats_checked, want.out_byte, want.last,
                              rsp_data.out_byte, rsp_data.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   initial begin
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         int stall;
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 8)) @(negedge clock);
         stall = rsp_stall_on ? pick_gap() : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // unused fields carry random junk so they are seen to be ignored
   function automatic pbfe_pkg::req_type make_req(input logic [1:0] op,
                                                  input logic [28:0] field,
                                                  input logic [31:0] ival,
                                                  input logic [31:0] len,
                                                  input logic [7:0] data);
      pbfe_pkg::req_type r;
      r.operation    = op;
      r.field_number = 29'($urandom);
      r.int_value    = $urandom;
      r.length       = $urandom;
      r.data_byte    = 8'($urandom);
      case (op)
         pbfe_pkg::OP_INTEGER: begin
            r.field_number = field;
            r.int_value    = ival;
         end
         pbfe_pkg::OP_HEADER: begin
            r.field_number = field;
            r.length       = len;
         end
         pbfe_pkg::OP_RAW: r.data_byte = data;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input pbfe_pkg::req_type it);
      int gap;
      @(negedge clock);
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (wire_bytes_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [28:0] rand_field();
      case ($urandom_range(0, 3))
         0:       return 29'($urandom_range(1, 15));
         1:       return 29'($urandom_range(16, 2047));
         2:       return 29'($urandom_range(2048, 536870911));
         default: return 29'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_int();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 127);
         1:       return $urandom_range(128, 16383);
         2:       return -$urandom_range(1, 200);
         3:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_corner_items();
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd1, 32'd0, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd1, 32'd1, 0, 0));
      // tag and value at the one/two byte boundary
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd15, 32'd127, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd16, 32'd128, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd1, 32'hFFFF_FFFF, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'h1FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
      // longest item: five tag bytes plus ten value bytes
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'h1FFF_FFFF, 32'h8000_0000, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd2047, 32'd300, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'h0AAA_AAAA, 32'hAAAA_AAAA, 0, 0));
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'h1555_5555, 32'h5555_5555, 0, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'd1, 0, 32'd0, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'd2, 0, 32'd127, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'd3, 0, 32'd128, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'h1FFF_FFFF, 0, 32'hFFFF_FFFF, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'd16383, 0, 32'd16384, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'h1555_5555, 0, 32'hAAAA_AAAA, 0));
      send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'h00));
      send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'hFF));
      send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'h5A));
      // field number zero gives a single zero-field tag byte
      send_item(make_req(pbfe_pkg::OP_INTEGER, 29'd0, 32'd5, 0, 0));
      send_item(make_req(pbfe_pkg::OP_HEADER, 29'd0, 0, 32'd3, 0));
      // unused operation code, random and all-ones contents
      send_item(make_req(pbfe_pkg::OP_UNUSED, 0, 0, 0, 0));
      send_item('1);
   endtask

   // mostly well-formed messages: headers followed by their payload, integer fields
   task automatic test_message_stream(input int n_items);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            len = $urandom_range(0, 6);
            send_item(make_req(pbfe_pkg::OP_HEADER, rand_field(), 0, len, 0));
            repeat (len) send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'($urandom)));
            sent += 1 + len;
         end else if (r < 80) begin
            send_item(make_req(pbfe_pkg::OP_INTEGER, rand_field(), rand_int(), 0, 0));
            sent++;
         end else if (r < 88) begin
            send_item(make_req(pbfe_pkg::OP_HEADER, rand_field(), 0, $urandom, 0));
            sent++;
         end else if (r < 93) begin
            send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'($urandom)));
            sent++;
         end else begin
            send_item(make_req(pbfe_pkg::OP_UNUSED, 0, 0, 0, 0));
         end
      end
   endtask

   task automatic test_pause_and_drain();
      test_message_stream(30);
      hold_until_drained();
      test_message_stream(30);
   endtask

   task automatic test_back_to_back();
      tx_gaps_on   = 1'b0;
      rsp_stall_on = 1'b0;
      test_message_stream(40);
      repeat (40) send_item(make_req(pbfe_pkg::OP_RAW, 0, 0, 0, 8'($urandom)));
      tx_gaps_on   = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      errors       = 0;
      tx_gaps_on   = 1'b1;
      rsp_stall_on = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_corner_items();
      test_message_stream(300);
      test_pause_and_drain();
      test_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;
      while (wire_bytes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tb: sent %0d integer, %0d header, %0d raw and %0d unused-code items",
               items_by_op[pbfe_pkg::OP_INTEGER], items_by_op[pbfe_pkg::OP_HEADER],
               items_by_op[pbfe_pkg::OP_RAW], items_by_op[pbfe_pkg::OP_UNUSED]);
      $display("tb: %0d wire bytes checked, %0d mismatches", beats_checked, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/pbfe_pkg.sv
hw/rtl/pbfe_front.sv
hw/rtl/pbfe_queue.sv
hw/rtl/pbfe_back.sv
hw/rtl/protobuf_field_encoder.sv
verif/protobuf_field_encoder_tb.sv
